// File: rtl/pami_pkg.sv
// Shared types, constants and register indexes for the modulation index unit.
`timescale 1ns / 1ps
package pami_pkg;

  localparam int unsigned NumBinsDefault   = 18;
  localparam int unsigned MaxWindowDefault = 65536;

  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_PHASE_START = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BINS_IN_USE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BIN_SCALE   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LOG_BINS    = 2'd3;

  localparam logic signed [15:0] PHASE_START_RST = -16'sd25736;
  localparam logic [6:0]         BINS_IN_USE_RST = 7'd18;
  localparam logic [23:0]        BIN_SCALE_RST   = 24'd187733;
  localparam logic [18:0]        LOG_BINS_RST    = 19'd189423;

  typedef struct packed {
    logic signed [15:0] phase;
    logic [15:0]        amplitude;
    logic               window_end;
  } sample_t;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [15:0] bin_mean;
    logic [16:0] mod_index;
    logic        all_zero;
    logic        final_res;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  // Start and busy handshake between the control and the divider.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;

endpackage

// File: rtl/pami_if.sv
// Valid/ready stream interface used for all channels of the block.
`timescale 1ns / 1ps
interface pami_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pami_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pami_div #(
  parameter int unsigned NumW = 56,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    diff  = trial - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      if (!diff[DenW]) begin
        rem_d = diff;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

// File: rtl/phase_amplitude_modulation_index_unit.sv
// Top level of the phase-amplitude modulation index unit.
`timescale 1ns / 1ps
// Samples are binned by phase and accumulated into a sum and count memory
// with one read-modify-write per sample, in the steps accept and read,
// update, write back. On the sample flagged as window end the unit walks
// the bins: each mean takes a division and its log2 16 squaring steps. The
// totals then pass through one log2 and two divisions, unless the total or
// the log_bins register is zero. Results leave one per bin through an
// output register, and while they drain the bins are cleared one per cycle.
// After reset the bins are cleared before the first sample is taken.
module phase_amplitude_modulation_index_unit #(
  parameter int unsigned NumBins   = pami_pkg::NumBinsDefault,
  parameter int unsigned MaxWindow = pami_pkg::MaxWindowDefault
) (
  input logic  clk_i,
  input logic  rst_ni,
  pami_if.sink   in_i,
  pami_if.sink   cfg_i,
  pami_if.source out_o
);
  import pami_pkg::*;

  localparam int unsigned BinW = (NumBins > 1) ? $clog2(NumBins) : 1;
  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam int unsigned SumW = 32;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_UPD,
    S_MRD, S_MDIV, S_MWAIT, S_MLOG, S_MLOGW, S_MACC,
    S_TOT, S_TLOG, S_TLOGW, S_SDIV, S_SWAIT, S_QDIV, S_QWAIT,
    S_ORD, S_OUT, S_OWAIT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic signed [15:0] phase_start_q;
  logic [6:0]         bins_in_use_q;
  logic [23:0]        bin_scale_q;
  logic [18:0]        log_bins_q;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_start_q <= PHASE_START_RST;
      bins_in_use_q <= BINS_IN_USE_RST;
      bin_scale_q   <= BIN_SCALE_RST;
      log_bins_q    <= LOG_BINS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_PHASE_START: phase_start_q <= cfg_i.data.data[15:0];
        REG_BINS_IN_USE: bins_in_use_q <= cfg_i.data.data[6:0];
        REG_BIN_SCALE:   bin_scale_q   <= cfg_i.data.data[23:0];
        REG_LOG_BINS:    log_bins_q    <= cfg_i.data.data[18:0];
        default: ;
      endcase
    end
  end

  logic [BinW-1:0] last_bin;
  always_comb begin
    if (bins_in_use_q < 7'd2) last_bin = BinW'(1);
    else if (32'(bins_in_use_q) > NumBins) last_bin = BinW'(NumBins - 1);
    else last_bin = BinW'(bins_in_use_q - 7'd1);
  end

  // Shared divider.
  logic        div_start, div_busy;
  logic [55:0] div_num, div_quo;
  logic [31:0] div_den;
  logic [15:0] sum_quo;
  assign sum_quo = div_quo[15:0];

  // Bin memories: sum and count share an address, plus the mean store.
  logic [SumW+CntW-1:0] acc_mem [NumBins];
  logic [15:0]          mean_mem [NumBins];
  logic [BinW-1:0]      rd_addr, wr_addr;
  logic                 wr_en;
  logic [SumW+CntW-1:0] wr_data, rd_data_q;
  logic                 mwr_en;
  logic [15:0]          mean_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) acc_mem[wr_addr] <= wr_data;
    rd_data_q <= acc_mem[rd_addr];
    if (mwr_en) mean_mem[wr_addr] <= sum_quo[15:0];
    mean_rd_q <= mean_mem[rd_addr];
  end

  // Clearing pass after reset; the bins are also cleared while results drain.
  logic [BinW:0] clr_q;
  logic          clr_busy;
  assign clr_busy = (clr_q != (BinW+1)'(NumBins));

  // Binning, registered on accept.
  logic signed [16:0] off;
  logic [40:0]        prod;
  logic [11:0]        pbin;
  logic [BinW-1:0]    bin_d, bin_q;
  logic [15:0]        amp_q;
  logic               last_q;

  assign off  = 17'(in_i.data.phase) - 17'(phase_start_q);
  assign prod = off[15:0] * bin_scale_q;
  assign pbin = prod[40:29];
  always_comb begin
    if (off[16] || off == '0) bin_d = '0;
    else if (pbin >= 12'(last_bin)) bin_d = last_bin;
    else bin_d = BinW'(pbin);
  end

  assign in_i.ready = (state_q == S_IDLE) && !clr_busy;

  pami_div #(.NumW(56), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  logic [31:0] lg_y_q;
  logic [15:0] lg_f_q;
  logic [4:0]  lg_e_q;
  logic [4:0]  lg_n_q;
  logic [63:0] lg_sq;
  assign lg_sq = lg_y_q * lg_y_q;

  function automatic logic [4:0] msb_pos(input logic [21:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 22; i++) if (x[i]) p = 5'(i);
    return p;
  endfunction

  logic [BinW-1:0] idx_q;
  logic [21:0]     total_q;
  logic [47:0]     s_q;
  logic [20:0]     lt_q;
  logic [20:0]     h2;
  logic [16:0]     mi_q;
  logic            zf_q;
  logic [21:0]     lg_x;

  assign h2 = (21'(div_quo) > lt_q) ? '0 : lt_q - 21'(div_quo);
  assign lg_x = (state_q == S_TLOG) ? total_q : 22'(sum_quo);

  result_t res_q;
  logic    out_v_q;
  assign out_o.valid = out_v_q;
  assign out_o.data  = res_q;

  always_comb begin
    rd_addr   = idx_q;
    wr_addr   = idx_q;
    wr_en     = 1'b0;
    wr_data   = '0;
    mwr_en    = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (clr_busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_q[BinW-1:0];
    end
    case (state_q)
      S_IDLE: rd_addr = bin_d;
      S_RD: rd_addr = bin_q;
      S_UPD: begin
        wr_addr = bin_q;
        if (32'(rd_data_q[CntW-1:0]) < MaxWindow) begin
          wr_en   = 1'b1;
          wr_data = {rd_data_q[SumW+CntW-1:CntW] + 32'(amp_q),
                     rd_data_q[CntW-1:0] + 1'b1};
        end
      end
      S_MDIV: begin
        // An empty bin is divided as zero by one so that its mean reads zero.
        div_start = 1'b1;
        if (rd_data_q[CntW-1:0] != '0) begin
          div_num = 56'(rd_data_q[SumW+CntW-1:CntW]);
          div_den = 32'(rd_data_q[CntW-1:0]);
        end else begin
          div_num = '0;
          div_den = 32'd1;
        end
      end
      S_MLOG: mwr_en = 1'b1;
      S_SDIV: begin
        div_start = 1'b1;
        div_num   = 56'(s_q);
        div_den   = 32'(total_q);
      end
      S_QDIV: begin
        div_start = 1'b1;
        div_num   = 56'(h2) * 56'(LN2_Q16);
        div_den   = 32'(log_bins_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      clr_q   <= '0;
      out_v_q <= 1'b0;
      idx_q   <= '0;
      total_q <= '0;
    end else begin
      if (clr_busy) clr_q <= clr_q + 1'b1;
      if (out_v_q && out_o.ready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_i.valid && in_i.ready) begin
          bin_q   <= bin_d;
          amp_q   <= in_i.data.amplitude;
          last_q  <= in_i.data.window_end;
          state_q <= S_RD;
        end
        S_RD: state_q <= S_UPD;
        S_UPD: begin
          idx_q   <= '0;
          total_q <= '0;
          s_q     <= '0;
          state_q <= last_q ? S_MRD : S_IDLE;
        end
        S_MRD: state_q <= S_MDIV;
        S_MDIV: state_q <= S_MWAIT;
        S_MWAIT: if (!div_busy) begin
          state_q <= S_MLOG;
        end
        S_MLOG, S_TLOG: begin
          lg_e_q  <= msb_pos(lg_x);
          lg_y_q  <= 32'(lg_x) << (30 - msb_pos(lg_x));
          lg_f_q  <= '0;
          lg_n_q  <= 5'd16;
          if (state_q == S_MLOG) begin
            total_q <= total_q + 22'(sum_quo);
            state_q <= S_MLOGW;
          end else begin
            state_q <= S_TLOGW;
          end
        end
        S_MLOGW, S_TLOGW: begin
          if (lg_n_q != '0) begin
            lg_n_q <= lg_n_q - 1'b1;
            if (lg_sq[61]) begin
              lg_y_q <= lg_sq[62:31];
              lg_f_q <= {lg_f_q[14:0], 1'b1};
            end else begin
              lg_y_q <= lg_sq[61:30];
              lg_f_q <= {lg_f_q[14:0], 1'b0};
            end
          end else if (state_q == S_MLOGW) begin
            state_q <= S_MACC;
          end else begin
            lt_q    <= {lg_e_q, lg_f_q};
            state_q <= S_SDIV;
          end
        end
        S_MACC: begin
          if (sum_quo != '0) s_q <= s_q + 48'(sum_quo) * 48'({lg_e_q, lg_f_q});
          if (idx_q == last_bin) state_q <= S_TOT;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_MRD;
          end
        end
        S_TOT: begin
          zf_q <= (total_q == '0);
          mi_q <= '0;
          state_q <= (total_q == '0 || log_bins_q == '0) ? S_ORD : S_TLOG;
        end
        S_SDIV: state_q <= S_SWAIT;
        S_SWAIT: if (!div_busy) state_q <= S_QDIV;
        S_QDIV: state_q <= S_QWAIT;
        S_QWAIT: if (!div_busy) begin
          mi_q    <= (div_quo >= 56'd65536) ? '0 : 17'(56'd65536 - div_quo);
          state_q <= S_ORD;
        end
        S_ORD: begin
          idx_q   <= '0;
          clr_q   <= '0;
          state_q <= S_OUT;
        end
        S_OUT: if (!out_v_q || out_o.ready) begin
          state_q <= S_OWAIT;
        end
        S_OWAIT: begin
          out_v_q             <= 1'b1;
          res_q.bin_index     <= 6'(idx_q);
          res_q.bin_mean      <= mean_rd_q;
          res_q.final_res     <= (idx_q == last_bin);
          res_q.mod_index     <= (idx_q == last_bin) ? mi_q : '0;
          res_q.all_zero      <= (idx_q == last_bin) ? zf_q : 1'b0;
          idx_q               <= idx_q + 1'b1;
          state_q             <= (idx_q == last_bin) ? S_IDLE : S_OUT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != S_IDLE) |-> !in_i.ready;
  endproperty
  assert property (p_no_accept_busy) else $error("sample taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |=> out_v_q)
    else $error("result dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_o.data.final_res) |-> (out_o.data.bin_index == 6'(last_bin)))
    else $error("final result on wrong bin");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SDIV) |-> (total_q != '0))
    else $error("entropy division by zero total");
endmodule
